### hw/rtl/sds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants for the sprite depth sort
// Field widths, register indexes, controller states and command structs.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int POS_W       = 32;
  localparam int DIR_W       = 16;
  localparam int KEY_W       = 51;
  localparam int IDX_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_X = 3'd0,
    REG_CAM_Y = 3'd1,
    REG_CAM_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MUL,
    ST_SUM,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch input beat, form differences
    logic multiply;    // register the three products
    logic store;       // write key into the batch store
    logic scan_start;  // clear scan bookkeeping
    logic scan_step;   // examine one stored entry
    logic emit_load;   // move best entry to output register
    logic out_pop;     // output beat taken
    logic batch_clear; // empty the batch
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;        // entry count at capacity
    logic empty;       // no entries left unemitted
    logic scan_done;   // all entries examined
    logic last_left;   // exactly one entry remains
  } dp_stat_t;

endpackage

### hw/rtl/sds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_datapath: key arithmetic, batch store and selection scan
// Computes the depth key over two stages, stores it, and finds the largest
// remaining key (earliest on ties) by scanning the store one entry a cycle.
// ----------------------------------------------------------------------------
module sds_datapath import sds_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [POS_W-1:0] cam_x,
  input  logic signed [POS_W-1:0] cam_y,
  input  logic signed [POS_W-1:0] cam_z,
  input  logic signed [DIR_W-1:0] dir_x,
  input  logic signed [DIR_W-1:0] dir_y,
  input  logic signed [DIR_W-1:0] dir_z,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  output logic [IDX_W-1:0]        entry_index,
  output logic signed [KEY_W-1:0] depth_key,
  output logic                    is_last,
  output logic                    overflowed,
  input  logic                    drop
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = POS_W + 1 + DIR_W;

  logic signed [POS_W:0]   diff_x, diff_y, diff_z;
  logic signed [DIR_W-1:0] dx, dy, dz;
  logic signed [PW-1:0]    prod_x, prod_y, prod_z;
  logic signed [KEY_W-1:0] key_sum;

  logic signed [KEY_W-1:0] key_mem [CAPACITY];
  logic [CAPACITY-1:0]     done;
  logic [CW-1:0]           entry_count;
  logic [CW-1:0]           remain;
  logic                    overflow_flag;

  logic [CW-1:0]           scan_ptr;
  logic signed [KEY_W-1:0] scan_key;
  logic                    best_valid;
  logic signed [KEY_W-1:0] best_key;
  logic [AW-1:0]           best_idx;

  assign key_sum = KEY_W'(prod_x) + KEY_W'(prod_y) + KEY_W'(prod_z);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diff_x <= (POS_W+1)'(pos_x) - (POS_W+1)'(cam_x);
      diff_y <= (POS_W+1)'(pos_y) - (POS_W+1)'(cam_y);
      diff_z <= (POS_W+1)'(pos_z) - (POS_W+1)'(cam_z);
      dx <= dir_x;
      dy <= dir_y;
      dz <= dir_z;
    end
    if (cmd.multiply) begin
      prod_x <= diff_x * dx;
      prod_y <= diff_y * dy;
      prod_z <= diff_z * dz;
    end
    if (cmd.store) begin
      key_mem[entry_count[AW-1:0]] <= key_sum;
    end
  end

  // registered store read for the scan
  always_ff @(posedge clk) begin
    scan_key <= key_mem[scan_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      remain        <= '0;
      overflow_flag <= 1'b0;
      done          <= '0;
      scan_ptr      <= '0;
      best_valid    <= 1'b0;
    end else begin
      if (drop) overflow_flag <= 1'b1;
      if (cmd.store) begin
        entry_count <= entry_count + 1'b1;
        remain      <= remain + 1'b1;
      end
      if (cmd.scan_start) begin
        scan_ptr   <= '0;
        best_valid <= 1'b0;
      end
      if (cmd.scan_step) begin
        // scan_key holds entry scan_ptr-1 (read issued last cycle)
        if (scan_ptr != '0 && !done[scan_ptr[AW-1:0] - 1'b1] &&
            (!best_valid || scan_key > best_key)) begin
          best_valid <= 1'b1;
          best_key   <= scan_key;
          best_idx   <= AW'(scan_ptr - 1'b1);
        end
        scan_ptr <= scan_ptr + 1'b1;
      end
      if (cmd.emit_load) begin
        done[best_idx] <= 1'b1;
        remain         <= remain - 1'b1;
      end
      if (cmd.batch_clear) begin
        entry_count   <= '0;
        remain        <= '0;
        overflow_flag <= 1'b0;
        done          <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      entry_index <= IDX_W'(best_idx);
      depth_key   <= best_key;
      is_last     <= (remain == CW'(1));
      overflowed  <= overflow_flag;
    end
  end

  assign stat.full      = (entry_count == CW'(CAPACITY));
  assign stat.empty     = (remain == '0);
  assign stat.scan_done = (scan_ptr == entry_count);
  assign stat.last_left = (remain == CW'(1));

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> best_valid)
    else $error("emit without a selected entry");
  assert property (@(posedge clk) disable iff (rst)
    remain <= entry_count)
    else $error("remaining count exceeds stored count");
  assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> entry_count < CW'(CAPACITY))
    else $error("store into full batch");

endmodule

### hw/rtl/sds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_ctrl: sequencer for load, key compute, scan and emit
// Drives the datapath through one beat at a time and the output handshake.
// ----------------------------------------------------------------------------
module sds_ctrl import sds_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     batch_end,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat,
  output logic     drop
);

  state_t state, state_next;
  logic   pend_end, pend_end_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      pend_end  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend_end  <= pend_end_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    pend_end_next  = pend_end;
    out_valid_next = out_valid;
    cmd            = '0;
    in_ready       = 1'b0;
    drop           = 1'b0;
    if (out_valid && out_ready) begin
      cmd.out_pop    = 1'b1;
      out_valid_next = 1'b0;
    end
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pend_end_next = batch_end;
          if (stat.full) begin
            drop = 1'b1;
            if (batch_end) begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end else begin
            cmd.capture = 1'b1;
            state_next  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.multiply = 1'b1;
        state_next   = ST_SUM;
      end
      ST_SUM: begin
        cmd.store = 1'b1;
        if (pend_end) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_SCAN: begin
        if (stat.empty) begin
          cmd.batch_clear = 1'b1;
          state_next      = ST_LOAD;
        end else begin
          cmd.scan_step = 1'b1;
          // one extra step consumes the registered read of the last entry
          if (stat.scan_done) state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit_load  = 1'b1;
          out_valid_next = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_LOAD)
    else $error("input taken outside load state");
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> !out_valid || out_ready)
    else $error("output register overwritten");
  assert property (@(posedge clk) disable iff (rst)
    cmd.batch_clear |-> !cmd.emit_load)
    else $error("clear during emit");

endmodule

### hw/rtl/sprite_depth_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_depth_sort: back-to-front depth sort of a sprite batch
// Loads sprite positions, keys them by view depth and emits them sorted.
// ----------------------------------------------------------------------------
// Load: each sprite steps through capture, multiply, then sum and store before
// the next sprite is taken; a dropped sprite is taken without these steps.
// Sort: each result comes from a one-entry-per-cycle scan of the key store over
// all N stored entries, so a batch of N runs N scans.
// Reset clears counts and flags; config resets to camera at origin, dir +z.
module sprite_depth_sort import sds_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [POS_W-1:0]      pos_x,
  input  logic signed [POS_W-1:0]      pos_y,
  input  logic signed [POS_W-1:0]      pos_z,
  input  logic                         batch_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [IDX_W-1:0]             entry_index,
  output logic signed [KEY_W-1:0]      depth_key,
  output logic                         is_last,
  output logic                         overflowed
);

  logic signed [POS_W-1:0] cam_x, cam_y, cam_z;
  logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
      dir_x <= '0;
      dir_y <= '0;
      dir_z <= DIR_W'(16384);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_X: cam_x <= cfg_data;
        REG_CAM_Y: cam_y <= cfg_data;
        REG_CAM_Z: cam_z <= cfg_data;
        REG_DIR_X: dir_x <= cfg_data[DIR_W-1:0];
        REG_DIR_Y: dir_y <= cfg_data[DIR_W-1:0];
        REG_DIR_Z: dir_z <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  sds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .batch_end (batch_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat),
    .drop      (drop)
  );

  sds_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cam_x       (cam_x),
    .cam_y       (cam_y),
    .cam_z       (cam_z),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .dir_z       (dir_z),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .cmd         (cmd),
    .stat        (stat),
    .entry_index (entry_index),
    .depth_key   (depth_key),
    .is_last     (is_last),
    .overflowed  (overflowed),
    .drop        (drop)
  );

endmodule
